// ===== hdl/bounded_ordered_list_assert.svh =====
// Assertion macros for the bounded ordered list.
// Expects signals named clk and rst_n in the including module's scope.
`ifndef BOUNDED_ORDERED_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define BOL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define BOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bol_pkg.sv =====
// Shared types and constants for the bounded ordered list.
// No dependencies; used by bol_cell and bounded_ordered_list.
`default_nettype none

package bol_pkg;

  // Default storage geometry.
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  // Command codes; the two unused codes fall to the default arm.
  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_LOCATE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } bol_result_code_t;

  // Command transaction payload.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  position;
    logic [31:0] value;
  } bol_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic        found;
    logic [3:0]  found_position;
    logic [4:0]  length;
    logic        is_full;
    logic        is_empty;
  } bol_out_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic        set_en;
    logic        ins_en;
    logic        rem_en;
    logic [4:0]  pos;
    logic [4:0]  count;
    logic [31:0] val;
  } bol_ctl_t;

  // Search and read information handed from cell to cell.
  typedef struct packed {
    logic        hit;
    logic [3:0]  fidx;
    logic [31:0] rd;
  } bol_chain_t;

endpackage

`default_nettype wire

// ===== hdl/bol_cell.sv =====
// One storage cell of the bounded ordered list row.
// Depends on bol_pkg; instantiated DEPTH times by bounded_ordered_list.
`default_nettype none

module bol_cell #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned WORD_BITS = bol_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire bol_pkg::bol_ctl_t    ctl,
  input  wire logic [WORD_BITS-1:0] left_word,
  input  wire logic [WORD_BITS-1:0] right_word,
  output logic      [WORD_BITS-1:0] word,
  input  wire bol_pkg::bol_chain_t  chain_in,
  output bol_pkg::bol_chain_t       chain_out
);

  localparam logic [31:0] IDX = 32'(INDEX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;
  logic                 at_pos;
  logic                 past_pos;
  logic                 live;
  logic                 match;
  logic                 first;

  // Where this cell sits relative to the command position and the length.
  assign at_pos   = ({27'b0, ctl.pos} == IDX);
  assign past_pos = (IDX > {27'b0, ctl.pos});
  assign live     = (IDX < {27'b0, ctl.count});

  // Next word: write in place, shift up from the left, or shift down from the right.
  always_comb begin
    word_nxt = word_r;
    if (ctl.set_en && at_pos) begin
      word_nxt = WORD_BITS'(ctl.val);
    end else if (ctl.ins_en && past_pos) begin
      word_nxt = left_word;
    end else if (ctl.ins_en && at_pos) begin
      word_nxt = WORD_BITS'(ctl.val);
    end else if (ctl.rem_en && (past_pos || at_pos)) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

  // Search: only the first live match along the row reports its index.
  assign match = live && (word_r == WORD_BITS'(ctl.val));
  assign first = match && !chain_in.hit;

  assign chain_out.hit  = chain_in.hit | match;
  assign chain_out.fidx = chain_in.fidx | (first ? 4'(INDEX) : 4'd0);
  assign chain_out.rd   = chain_in.rd | (at_pos ? 32'(word_r) : 32'd0);

endmodule

`default_nettype wire

// ===== hdl/bounded_ordered_list.sv =====
// Bounded ordered list: command/result channels, a configuration write
// channel for the capacity, and the row of storage cells.
//
// Usage: a command transaction is taken at a rising edge with start high
// and busy low. busy stays low, so one command can be issued every cycle.
// Each command yields exactly one result transaction, shown on out_item
// with out_valid high for a single cycle, in the cycle after the command
// was taken (throughput one command per cycle). The cell row shifts,
// writes and compares all entries in the cycle the command is taken;
// the search and the read word ripple along the row of cells, which sets
// the cycle time.
// The receiver cannot stall: a result must be captured in its strobe cycle.
// The capacity register is written with cfg_valid and cfg_ready high;
// cfg_ready is always high. Write it only while no command is in flight.
// Reset (rst_n low, synchronous) empties the list and sets the capacity
// to DEPTH, limited to 31. Entry words are not cleared: positions at or
// above the length are never read, so no clearing pass is needed.
`default_nettype none

module bounded_ordered_list #(
  parameter int unsigned DEPTH     = bol_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = bol_pkg::WORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Command channel.
  input  wire logic             start,
  output logic                  busy,
  input  wire bol_pkg::bol_in_t in_item,
  // Result channel.
  output logic                  out_valid,
  output bol_pkg::bol_out_t     out_item,
  // Capacity register write channel.
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [4:0]       cfg_data
);

  `include "bounded_ordered_list_assert.svh"

  // Largest capacity that the length field and the storage can both hold.
  localparam int unsigned CAP_MAX = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [4:0]  CAP_LIM = 5'(CAP_MAX);

  logic [4:0]          cap_r;
  logic [4:0]          count_r;
  logic [4:0]          count_nxt;
  logic                out_valid_r;
  bol_pkg::bol_out_t   out_r;
  bol_pkg::bol_out_t   out_nxt;
  bol_pkg::bol_ctl_t   ctl;
  logic                fire;
  logic [4:0]          eff_cap;
  logic                in_range;
  logic                full_now;
  logic                ins_ok;

  logic [WORD_BITS-1:0] cell_word [DEPTH];
  bol_pkg::bol_chain_t  chain     [DEPTH+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign fire      = start && !busy;

  // Capacity as seen by the list, and the checks every command needs.
  assign eff_cap  = (cap_r > CAP_LIM) ? CAP_LIM : cap_r;
  assign in_range = (in_item.position < count_r);
  assign full_now = (count_r >= eff_cap);
  assign ins_ok   = !full_now && (in_item.position <= count_r);

  // Broadcast to the cell row; enables only for commands that will succeed.
  always_comb begin
    ctl.set_en = fire && (in_item.opcode == bol_pkg::OP_SET) && in_range;
    ctl.ins_en = fire && (in_item.opcode == bol_pkg::OP_INSERT) && ins_ok;
    ctl.rem_en = fire && (in_item.opcode == bol_pkg::OP_REMOVE) && in_range;
    ctl.pos    = in_item.position;
    ctl.count  = count_r;
    ctl.val    = in_item.value;
  end

  // Row of cells; each shifts with its neighbors and extends the search chain.
  assign chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_word[i+1];
    end

    bol_cell #(
      .INDEX     (i),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1])
    );
  end

  // Result of the current command and the new length.
  always_comb begin
    count_nxt              = count_r;
    out_nxt.status         = bol_pkg::ST_OK;
    out_nxt.data           = '0;
    out_nxt.found          = 1'b0;
    out_nxt.found_position = '0;
    case (in_item.opcode)
      bol_pkg::OP_GET: begin
        if (in_range) begin
          out_nxt.data = chain[DEPTH].rd;
        end else begin
          out_nxt.status = bol_pkg::ST_RANGE;
        end
      end
      bol_pkg::OP_SET: begin
        if (!in_range) begin
          out_nxt.status = bol_pkg::ST_RANGE;
        end
      end
      bol_pkg::OP_INSERT: begin
        if (full_now) begin
          out_nxt.status = bol_pkg::ST_FULL;
        end else if (!ins_ok) begin
          out_nxt.status = bol_pkg::ST_RANGE;
        end else begin
          count_nxt = count_r + 5'd1;
        end
      end
      bol_pkg::OP_REMOVE: begin
        if (in_range) begin
          out_nxt.data = chain[DEPTH].rd;
          count_nxt    = count_r - 5'd1;
        end else begin
          out_nxt.status = bol_pkg::ST_RANGE;
        end
      end
      bol_pkg::OP_LOCATE: begin
        out_nxt.found          = chain[DEPTH].hit;
        out_nxt.found_position = chain[DEPTH].fidx;
      end
      bol_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_nxt.length   = count_nxt;
    out_nxt.is_full  = (count_nxt >= eff_cap);
    out_nxt.is_empty = (count_nxt == 5'd0);
  end

  // Control state, capacity register and the registered result transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_LIM;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (fire) begin
        count_r <= count_nxt;
      end
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Every accepted command yields a result strobe in the next cycle.
  `BOL_ASSERT_NEXT(a_result_follows, fire, out_valid_r,
                   "result strobe missing after command")
  // No strobe appears without a command before it.
  `BOL_ASSERT_NEXT(a_no_spurious, !fire, !out_valid_r, "result strobe without a command")
  // The length never exceeds what the capacity limit allows.
  `BOL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CAP_LIM, "length above capacity limit")
  // An insert rejected as full leaves the length unchanged.
  `BOL_ASSERT_NOW(a_full_keeps, out_valid_r && (out_r.status == bol_pkg::ST_FULL),
                  out_r.length == $past(count_r), "full insert changed length")
  // A reported match lies inside the list.
  `BOL_ASSERT_NOW(a_found_inside, out_valid_r && out_r.found,
                  5'(out_r.found_position) < out_r.length, "match outside list")

endmodule

`default_nettype wire
